FILE: rtl/cfir_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfir_pkg: shared types and constants of the complex FIR filter
// Item layouts, the complex word stored in the tap and delay memories,
// sequencer state and the control bundle from sequencer to datapath.
// ----------------------------------------------------------------------------
package cfir_pkg;

	localparam int unsigned DATA_W      = 16;
	localparam int unsigned IDX_W       = 6;
	localparam int unsigned CNT_W       = 7;
	localparam int unsigned WORD_W      = 2 * DATA_W;
	localparam int unsigned OUT_SHIFT   = 15;
	localparam logic [WORD_W-1:0] ROUND_INIT = 32'd16384;
	localparam logic [CNT_W-1:0]  TAP_COUNT_RESET = 7'd63;

	typedef enum logic {
		OP_FILTER    = 1'b0,
		OP_TAP_WRITE = 1'b1
	} cfir_op_t;

	typedef struct packed {
		cfir_op_t                  op;
		logic [IDX_W-1:0]          tap_index;
		logic signed [DATA_W-1:0]  data_real;
		logic signed [DATA_W-1:0]  data_imag;
	} cfir_in_t;

	typedef struct packed {
		logic signed [DATA_W-1:0]  out_real;
		logic signed [DATA_W-1:0]  out_imag;
	} cfir_out_t;

	// Memory word: real part in the low half, imaginary in the high half
	typedef struct packed {
		logic signed [DATA_W-1:0]  im;
		logic signed [DATA_W-1:0]  re;
	} cfir_cplx_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_WAIT
	} cfir_state_t;

	// One tap step issued by the sequencer
	typedef struct packed {
		logic issue;   // memories are read at the tap address this cycle
		logic first;   // tap zero: uses the new sample, restarts the sum
		logic last;    // final step of this sample
		logic use_mac; // product counts toward the sum
	} cfir_seq_t;

endpackage

FILE: rtl/complex_fixed_point_fir.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// complex_fixed_point_fir: direct-form complex FIR filter, 16-bit samples/taps
//
// Request channel (req_valid/req_ready/req_data): an item with op = tap write
// stores one complex coefficient at tap_index and gives no result. An item with
// op = filter pushes the sample into the delay line and produces one result on
// the response channel (rsp_valid/rsp_ready). A sample runs n tap steps, with
// n = min(tap_count, MAX_TAPS) (one step when n is zero): one complex MAC per
// tap per cycle through the coefficient and delay RAM read ports. The next item
// is accepted only once the finished sum has moved into the output register.
// tap_count is written through cfg_we/cfg_wdata; write it only while the block
// is idle, the block itself does not enforce this.
// Reset clears both RAMs (valid bits) and sets tap_count to 63; no clearing
// pass is needed. The result sits in an output register; while the receiver
// stalls, the block still takes the next item and computes it, then holds
// that sum until the output register frees up.
// ----------------------------------------------------------------------------
module complex_fixed_point_fir #(
	parameter int unsigned MAX_TAPS = 64
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        req_valid,
	output logic                        req_ready,
	input  cfir_pkg::cfir_in_t          req_data,
	output logic                        rsp_valid,
	input  logic                        rsp_ready,
	output cfir_pkg::cfir_out_t         rsp_data,
	input  logic                        cfg_we,
	input  logic [cfir_pkg::CNT_W-1:0]  cfg_wdata
);
	import cfir_pkg::*;

	localparam int unsigned AW = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
	localparam int unsigned NW = $clog2(MAX_TAPS + 1);

	logic [CNT_W-1:0] tap_count_q;
	logic [NW-1:0]    n_cfg;
	logic             accept, start, coef_we, idle, done, take;
	logic [AW-1:0]    addr;
	cfir_seq_t        seq;
	cfir_cplx_t       sample_q, req_word, dly_rd, coef_rd, dly_wr;
	cfir_out_t        result, rsp_q;
	logic             rsp_valid_q;

	// tap count register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tap_count_q <= TAP_COUNT_RESET;
		end else if (cfg_we) begin
			tap_count_q <= cfg_wdata;
		end
	end

	assign n_cfg = (32'(tap_count_q) > MAX_TAPS) ? NW'(MAX_TAPS) : NW'(tap_count_q);

	// request decode
	assign accept      = req_valid && req_ready;
	assign start       = accept && (req_data.op == OP_FILTER);
	assign coef_we     = accept && (req_data.op == OP_TAP_WRITE) &&
	                     (32'(req_data.tap_index) < MAX_TAPS);
	assign req_word.re = req_data.data_real;
	assign req_word.im = req_data.data_imag;
	assign req_ready   = idle;

	// new sample held for the whole pass
	always_ff @(posedge clk) begin
		if (start) begin
			sample_q <= req_word;
		end
	end

	cfir_ctrl #(
		.AW (AW),
		.NW (NW)
	) u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.n      (n_cfg),
		.take   (take),
		.idle   (idle),
		.addr   (addr),
		.seq    (seq)
	);

	// delay line: step k reads entry k and writes it with old entry k-1 for k above one;
	// steps zero and one write the new sample, so entries zero and one both take it
	assign dly_wr = (seq.first || (addr == AW'(1))) ? sample_q : dly_rd;

	cfir_mem #(
		.DEPTH (MAX_TAPS),
		.AW    (AW),
		.DW    (WORD_W)
	) u_dly_mem (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (seq.issue),
		.waddr  (addr),
		.wdata  (dly_wr),
		.raddr  (addr),
		.rdata  (dly_rd)
	);

	cfir_mem #(
		.DEPTH (MAX_TAPS),
		.AW    (AW),
		.DW    (WORD_W)
	) u_coef_mem (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (coef_we),
		.waddr  (AW'(req_data.tap_index)),
		.wdata  (req_word),
		.raddr  (addr),
		.rdata  (coef_rd)
	);

	cfir_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.seq    (seq),
		.sample (sample_q),
		.dly    (dly_rd),
		.coef   (coef_rd),
		.take   (take),
		.done   (done),
		.result (result)
	);

	// output register
	assign take = done && (!rsp_valid_q || rsp_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (take) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			rsp_q <= result;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_data  = rsp_q;

	// checks
	a_idle_no_pending: assert property (@(posedge clk) disable iff (!arst_n)
		idle |-> !done)
		else $error("finished sum pending while sequencer is idle");

	a_issue_blocks_req: assert property (@(posedge clk) disable iff (!arst_n)
		seq.issue |-> !req_ready)
		else $error("request accepted during a tap pass");

	a_take_fills_out: assert property (@(posedge clk) disable iff (!arst_n)
		take |=> rsp_valid)
		else $error("sum taken but no result presented");

	a_done_needs_pass: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(done) |-> !idle)
		else $error("sum finished outside a sample pass");

endmodule

FILE: rtl/cfir_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfir_mem: single-port-write, single-port-read synchronous RAM
// Registered read, read-before-write on the same address.
// Per-entry valid bits, cleared by reset, make unwritten entries read as zero.
// ----------------------------------------------------------------------------
module cfir_mem #(
	parameter int unsigned DEPTH = 64,
	parameter int unsigned AW    = 6,
	parameter int unsigned DW    = 32
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);

	logic [DW-1:0]    mem [DEPTH];
	logic [DW-1:0]    rdata_q;
	logic [DEPTH-1:0] vld_q;
	logic             rvld_q;

	// valid bits and read-side valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= '0;
			rvld_q <= 1'b0;
		end else begin
			rvld_q <= vld_q[raddr];
			if (we) begin
				vld_q[waddr] <= 1'b1;
			end
		end
	end

	// storage array; the read sees the old contents on a same-address write
	always_ff @(posedge clk) begin
		rdata_q <= mem[raddr];
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	assign rdata = rvld_q ? rdata_q : '0;

endmodule

FILE: rtl/cfir_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfir_ctrl: tap sequencer
// Walks the tap address once from zero to n-1 (zero alone if n = 0) per sample,
// then waits until the finished sum has moved into the output register.
// ----------------------------------------------------------------------------
module cfir_ctrl #(
	parameter int unsigned AW = 6,
	parameter int unsigned NW = 7
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [NW-1:0]      n,
	input  logic               take,
	output logic               idle,
	output logic [AW-1:0]      addr,
	output cfir_pkg::cfir_seq_t seq
);
	import cfir_pkg::*;

	cfir_state_t   state_q, state_d;
	logic [AW-1:0] k_q, k_d;
	logic [NW-1:0] n_q;
	logic          at_end;

	// state, tap counter and latched tap count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			k_q     <= '0;
			n_q     <= '0;
		end else begin
			state_q <= state_d;
			k_q     <= k_d;
			if (start) begin
				n_q <= n;
			end
		end
	end

	// last tap when k+1 reaches n; a zero count still issues one step
	assign at_end = (n_q == '0) || (((NW+1)'(k_q) + (NW+1)'(1)) == (NW+1)'(n_q));

	// next state and step outputs
	always_comb begin
		state_d = state_q;
		k_d     = k_q;
		seq     = '0;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_d = ST_RUN;
					k_d     = '0;
				end
			end
			ST_RUN: begin
				seq.issue   = 1'b1;
				seq.first   = (k_q == '0);
				seq.last    = at_end;
				seq.use_mac = (n_q != '0);
				if (at_end) begin
					state_d = ST_WAIT;
				end else begin
					k_d = k_q + AW'(1);
				end
			end
			ST_WAIT: begin
				if (take) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign idle = (state_q == ST_IDLE);
	assign addr = k_q;

endmodule

FILE: rtl/cfir_mac.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfir_mac: complex multiply-accumulate datapath
// s1: memory data arrives, operand select. s2: four 16x16 products.
// Then the 32-bit wrapping accumulators, preloaded with the rounding term.
// ----------------------------------------------------------------------------
module cfir_mac (
	input  logic                 clk,
	input  logic                 arst_n,
	input  cfir_pkg::cfir_seq_t  seq,
	input  cfir_pkg::cfir_cplx_t sample,
	input  cfir_pkg::cfir_cplx_t dly,
	input  cfir_pkg::cfir_cplx_t coef,
	input  logic                 take,
	output logic                 done,
	output cfir_pkg::cfir_out_t  result
);
	import cfir_pkg::*;

	cfir_seq_t                seq_s1, seq_s2;
	cfir_cplx_t               opnd;
	logic signed [DATA_W-1:0] a_re, a_im, c_re, c_im;
	logic signed [WORD_W-1:0] pac_s2, pbd_s2, pad_s2, pbc_s2;
	logic [WORD_W-1:0]        term_re, term_im;
	logic [WORD_W-1:0]        acc_re_q, acc_im_q;
	logic                     done_q;

	// step tags follow the memory and multiplier latency
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_s1 <= '0;
			seq_s2 <= '0;
			done_q <= 1'b0;
		end else begin
			seq_s1 <= seq;
			seq_s2 <= seq_s1;
			if (seq_s2.issue && seq_s2.last) begin
				done_q <= 1'b1;
			end else if (take) begin
				done_q <= 1'b0;
			end
		end
	end

	// tap zero takes the new sample, the rest the delay memory
	assign opnd = seq_s1.first ? sample : dly;
	assign a_re = opnd.re;
	assign a_im = opnd.im;
	assign c_re = coef.re;
	assign c_im = coef.im;

	// products
	always_ff @(posedge clk) begin
		pac_s2 <= a_re * c_re;
		pbd_s2 <= a_im * c_im;
		pad_s2 <= a_re * c_im;
		pbc_s2 <= a_im * c_re;
	end

	assign term_re = seq_s2.use_mac ? WORD_W'(pac_s2 - pbd_s2) : '0;
	assign term_im = seq_s2.use_mac ? WORD_W'(pad_s2 + pbc_s2) : '0;

	// wrapping accumulators
	always_ff @(posedge clk) begin
		if (seq_s2.issue) begin
			acc_re_q <= (seq_s2.first ? ROUND_INIT : acc_re_q) + term_re;
			acc_im_q <= (seq_s2.first ? ROUND_INIT : acc_im_q) + term_im;
		end
	end

	assign done            = done_q;
	assign result.out_real = acc_re_q[OUT_SHIFT +: DATA_W];
	assign result.out_imag = acc_im_q[OUT_SHIFT +: DATA_W];

endmodule
